[hdl/pci_pkg.sv]
// Shared types, field widths and codes for the cone isolation block.
package pci_pkg;

  localparam int ANGLE_BITS        = 12;
  localparam int PT_BITS           = 16;
  localparam int MAX_PARTICLES_DEF = 1024;

  localparam int IDX_W      = 10;
  localparam int WEIGHT_W   = 9;
  localparam int RHO_W      = 16;
  localparam int MODE_W     = 2;
  localparam int RADIUS_W   = 25;
  localparam int AREA_W     = 16;
  localparam int SUM_W      = 25;
  localparam int ISO_W      = 17;
  localparam int IDX_LIM_W  = 17;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 25;

  // |sum| * 256 needs the width of the signed sum plus the Q8 shift
  localparam int DIVIDEND_W = SUM_W + 8;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam logic [MODE_W-1:0] MODE_RAW        = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AREA       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUBTRACTED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED   = 2'd3;

  localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_AREA   = 2'd2;

  localparam logic OP_START    = 1'b0;
  localparam logic OP_PARTICLE = 1'b1;

  localparam logic [RADIUS_W-1:0]     RADIUS_RESET   = 25'd38416;
  localparam logic [AREA_W-1:0]       AREA_RESET     = 16'd1158;
  localparam logic signed [SUM_W-1:0] NO_DENSITY_SUM = 25'sd3996;
  localparam logic [SUM_W-2:0]        SUM_MAX        = '1;
  localparam logic [ISO_W-1:0]        ISO_MAX        = 17'h0FFFF;
  localparam logic [ISO_W-1:0]        ISO_MIN        = 17'h10000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_AREA,
    ST_SUB,
    ST_DIVGO,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic capture;
    logic acc;
    logic area;
    logic fin;
    logic div_go;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic item_last;
    logic pt_zero;
    logic div_busy;
    logic out_free;
  } dp_stat_t;

endpackage

[hdl/pci_div.sv]
// Restoring divider, one quotient bit per cycle.
module pci_div import pci_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [PT_BITS-1:0]    divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  busy
);

  logic                  busy_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [PT_BITS-1:0]    rem_r;
  logic [PT_BITS-1:0]    dsr_r;
  logic [PT_BITS:0]      rem_sh;
  logic [PT_BITS:0]      rem_dif;
  logic                  ge;

  assign rem_sh  = {rem_r, quo_r[DIVIDEND_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_dif = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // dividend bits shift out of the top while quotient bits fill in below
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
      rem_r <= ge ? rem_dif[PT_BITS-1:0] : rem_sh[PT_BITS-1:0];
    end
  end

  assign quotient = quo_r;
  assign busy     = busy_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");

endmodule

[hdl/pci_dp.sv]
// Datapath: config registers, muon latch, cone test, accumulator, result register.
module pci_dp import pci_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_stat_t                     stat,
  input  logic                         in_opcode,
  input  logic signed [ANGLE_BITS-1:0] in_eta,
  input  logic signed [ANGLE_BITS-1:0] in_phi,
  input  logic [PT_BITS-1:0]           in_pt,
  input  logic [PT_BITS-1:0]           in_pt_subtracted,
  input  logic [WEIGHT_W-1:0]          in_weight,
  input  logic [IDX_W-1:0]             in_index,
  input  logic                         in_has_own_particle,
  input  logic [RHO_W-1:0]             in_rho,
  input  logic                         in_rho_valid,
  input  logic                         in_last,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_addr,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [OUT_DATA_W-1:0]        out_tdata
);

  localparam logic [IDX_LIM_W-1:0] IDX_LIMIT = IDX_LIM_W'(MAX_PARTICLES);
  localparam int SQ_ETA_W = 2 * ANGLE_BITS;
  localparam int SQ_PHI_W = 2 * ANGLE_BITS - 1;
  localparam int WPROD_W  = PT_BITS + WEIGHT_W;

  // configuration
  logic [MODE_W-1:0]   mode_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [AREA_W-1:0]   area_r;

  // muon latch
  logic signed [ANGLE_BITS-1:0] muon_eta_r;
  logic signed [ANGLE_BITS-1:0] muon_phi_r;
  logic [PT_BITS-1:0]           muon_pt_r;
  logic [IDX_W-1:0]             own_idx_r;
  logic                         own_valid_r;
  logic [RHO_W-1:0]             density_r;
  logic                         density_valid_r;

  // captured particle
  logic [SQ_ETA_W-1:0] sq_eta_r;
  logic [SQ_PHI_W-1:0] sq_phi_r;
  logic [WPROD_W-1:0]  wprod_r;
  logic [PT_BITS-1:0]  pt_r;
  logic [PT_BITS-1:0]  pts_r;
  logic                own_hit_r;
  logic                last_r;

  // accumulation and finish
  logic [SUM_W-2:0]          sum_r;
  logic [PT_BITS-1:0]        leader_r;
  logic [2*RHO_W-1:0]        area_prod_r;
  logic signed [SUM_W-1:0]   fin_sum_r;
  logic                      fin_valid_r;
  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  logic signed [ANGLE_BITS:0]     deta;
  logic signed [2*ANGLE_BITS+1:0] deta_sq;
  logic signed [ANGLE_BITS-1:0]   dphi;
  logic signed [2*ANGLE_BITS-1:0] dphi_sq;

  logic [RADIUS_W-1:0]    dr2;
  logic                   in_cone;
  logic [WPROD_W:0]       w_rnd;
  logic [PT_BITS-1:0]     w_sat;
  logic [PT_BITS-1:0]     contrib;
  logic [SUM_W-1:0]       sum_add;
  logic [SUM_W-2:0]       sum_acc;

  logic [2*RHO_W-1:0]      area_rnd;
  logic [SUM_W-1:0]        area_sub;
  logic signed [SUM_W-1:0] sum_sub;
  logic signed [SUM_W-1:0] fin_sum;
  logic                    fin_valid;

  logic [SUM_W-1:0]      sum_mag;
  logic [DIVIDEND_W-1:0] dividend;
  logic [DIVIDEND_W-1:0] quotient;
  logic                  div_busy;
  logic [ISO_W-1:0]      iso;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RAW;
      radius_r <= RADIUS_RESET;
      area_r   <= AREA_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:   mode_r   <= cfg_data[MODE_W-1:0];
        REG_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
        REG_AREA:   area_r   <= cfg_data[AREA_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      muon_eta_r      <= '0;
      muon_phi_r      <= '0;
      muon_pt_r       <= '0;
      own_idx_r       <= '0;
      own_valid_r     <= 1'b0;
      density_r       <= '0;
      density_valid_r <= 1'b0;
    end else if (cmd.capture && in_opcode == OP_START) begin
      muon_eta_r      <= in_eta;
      muon_phi_r      <= in_phi;
      muon_pt_r       <= in_pt;
      own_idx_r       <= in_index;
      own_valid_r     <= in_has_own_particle &&
                         ({(IDX_LIM_W-IDX_W)'(0), in_index} < IDX_LIMIT);
      density_r       <= in_rho;
      density_valid_r <= in_rho_valid;
    end
  end

  // squares and weighted product go into registers right at the accept
  always_comb begin
    deta    = {in_eta[ANGLE_BITS-1], in_eta} - {muon_eta_r[ANGLE_BITS-1], muon_eta_r};
    deta_sq = deta * deta;
    dphi    = in_phi - muon_phi_r;
    dphi_sq = dphi * dphi;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq_eta_r  <= deta_sq[SQ_ETA_W-1:0];
      sq_phi_r  <= dphi_sq[SQ_PHI_W-1:0];
      wprod_r   <= in_pt * in_weight;
      pt_r      <= in_pt;
      pts_r     <= in_pt_subtracted;
      own_hit_r <= own_valid_r && (in_index == own_idx_r);
      last_r    <= in_last;
    end
  end

  always_comb begin
    dr2     = {1'b0, sq_eta_r} + {2'b0, sq_phi_r};
    in_cone = (dr2 <= radius_r) && !own_hit_r;
    w_rnd   = {1'b0, wprod_r} + (WPROD_W+1)'(128);
    w_sat   = (|w_rnd[WPROD_W:PT_BITS+8]) ? '1 : w_rnd[PT_BITS+7:8];
    case (mode_r)
      MODE_SUBTRACTED: contrib = pts_r;
      MODE_WEIGHTED:   contrib = w_sat;
      default:         contrib = pt_r;
    endcase
    sum_add = {1'b0, sum_r} + {(SUM_W-PT_BITS)'(0), contrib};
    sum_acc = sum_add[SUM_W-1] ? SUM_MAX : sum_add[SUM_W-2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      leader_r <= '0;
    end else if (cmd.out_load || (cmd.capture && in_opcode == OP_START)) begin
      sum_r    <= '0;
      leader_r <= '0;
    end else if (cmd.acc && in_cone) begin
      sum_r <= sum_acc;
      if (contrib > leader_r) begin
        leader_r <= contrib;
      end
    end
  end

  // the rounded density term stays below 2^20, so the difference cannot underflow
  always_comb begin
    area_rnd  = area_prod_r + (2*RHO_W)'(2048);
    area_sub  = {(SUM_W-(2*RHO_W-12))'(0), area_rnd[2*RHO_W-1:12]};
    sum_sub   = $signed({1'b0, sum_r}) - $signed(area_sub);
    fin_sum   = $signed({1'b0, sum_r});
    fin_valid = 1'b1;
    if (mode_r == MODE_AREA) begin
      if (density_valid_r) begin
        fin_sum = sum_sub;
      end else begin
        fin_sum   = NO_DENSITY_SUM;
        fin_valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.area) begin
      area_prod_r <= density_r * area_r;
    end
    if (cmd.fin) begin
      fin_sum_r   <= fin_sum;
      fin_valid_r <= fin_valid;
    end
  end

  assign sum_mag  = fin_sum_r[SUM_W-1] ? (~fin_sum_r + 1'b1) : fin_sum_r;
  assign dividend = {sum_mag, 8'd0};

  pci_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dividend),
    .divisor  (muon_pt_r),
    .quotient (quotient),
    .busy     (div_busy)
  );

  // quotient is a magnitude; truncation toward zero, then clamp
  always_comb begin
    if (muon_pt_r == '0) begin
      iso = ISO_MAX;
    end else if (fin_sum_r[SUM_W-1]) begin
      iso = (quotient > DIVIDEND_W'(65536)) ? ISO_MIN : (~quotient[ISO_W-1:0] + 1'b1);
    end else begin
      iso = (quotient > DIVIDEND_W'(65535)) ? ISO_MAX : quotient[ISO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {5'd0, fin_valid_r && (muon_pt_r != '0), iso, leader_r, fin_sum_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  assign stat.item_last = last_r;
  assign stat.pt_zero   = (muon_pt_r == '0);
  assign stat.div_busy  = div_busy;
  assign stat.out_free  = !out_tvalid_r || out_tready;

  a_leader_in_sum: assert property (@(posedge clk) disable iff (!rst_n)
    {8'd0, leader_r} <= sum_r)
    else $error("leader exceeds running sum");

  a_load_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !div_busy)
    else $error("result loaded while divider busy");

  a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid_r || out_tready))
    else $error("result register overwritten");

endmodule

[hdl/pci_ctrl.sv]
// Controller state machine: sequences accept, accumulate, finish and divide.
module pci_ctrl import pci_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tuser,
  input  logic     in_tlast,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_PARTICLE) begin
            state_nxt = ST_ACC;
          end else if (in_tlast) begin
            state_nxt = ST_AREA;
          end
        end
      end
      ST_ACC:   state_nxt = stat.item_last ? ST_AREA : ST_IDLE;
      ST_AREA:  state_nxt = ST_SUB;
      ST_SUB:   state_nxt = stat.pt_zero ? ST_OUT : ST_DIVGO;
      ST_DIVGO: state_nxt = ST_DIV;
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = (state_r == ST_IDLE);
    cmd.capture  = in_tvalid && (state_r == ST_IDLE);
    cmd.acc      = (state_r == ST_ACC);
    cmd.area     = (state_r == ST_AREA);
    cmd.fin      = (state_r == ST_SUB);
    cmd.div_go   = (state_r == ST_DIVGO);
    cmd.out_load = (state_r == ST_OUT) && stat.out_free;
  end

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !stat.div_busy)
    else $error("request accepted while divider busy");

endmodule

[hdl/particle_cone_isolation.sv]
// Top level of the muon cone isolation block.
//
// Input channel in_*: a start request (in_tuser = 0) latches the muon's
// eta, phi, pt, own particle index and background density; particle
// requests (in_tuser = 1) follow. in_tlast on a request closes the muon's
// list and produces one result on out_*; requests without in_tlast
// produce none. cfg_* writes mode, squared cone radius and cone area; it
// is always ready. It is to be written only while the block is idle;
// the user must keep to this, as the block itself does not enforce it.
// Sequence: a start request is latched on acceptance. A particle is
// captured (squared distances), then cone-tested and accumulated; a
// request with in_tlast then runs area product, finish and the bit-serial
// divider for the Q8 ratio (skipped for muon pt zero) before the result
// is loaded and out_tvalid rises. No new request is taken meanwhile.
// The result sits in an output register: the next request is taken while
// it waits; a further result waits for the receiver before it is loaded.
// Reset restores the register defaults and clears muon, sum and leader.
module particle_cone_isolation import pci_pkg::*; #(
  parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // eta[11:0] phi[23:12] pt[39:24] pt_subtracted[55:40] weight[64:56]
  // index[74:65] has_own_particle[75] rho[91:76] rho_valid[92]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cone_sum[24:0] lead_pt[40:25] isolation[57:41] iso_valid[58]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pci_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pci_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_tuser),
    .in_eta              ($signed(in_tdata[11:0])),
    .in_phi              ($signed(in_tdata[23:12])),
    .in_pt               (in_tdata[39:24]),
    .in_pt_subtracted    (in_tdata[55:40]),
    .in_weight           (in_tdata[64:56]),
    .in_index            (in_tdata[74:65]),
    .in_has_own_particle (in_tdata[75]),
    .in_rho              (in_tdata[91:76]),
    .in_rho_valid        (in_tdata[92]),
    .in_last             (in_tlast),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_addr            (cfg_addr),
    .cfg_data            (cfg_data),
    .out_tready          (out_tready),
    .out_tvalid          (out_tvalid),
    .out_tdata           (out_tdata)
  );

endmodule

[sim/tb_particle_cone_isolation.sv]
// Self-checking testbench for the muon cone isolation block: directed and random requests.
module tb_particle_cone_isolation import pci_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SUM_HI     = longint'(SUM_MAX);
  localparam longint SUM_LO     = -SUM_HI - 1;
  localparam longint ISO_HI     = (longint'(1) << (ISO_W - 1)) - 1;
  localparam longint ISO_LO     = -ISO_HI - 1;
  localparam longint PT_LIMIT   = (longint'(1) << PT_BITS) - 1;
  localparam int     Q8_SHIFT   = 8;
  localparam longint Q8_ROUND   = longint'(1) << (Q8_SHIFT - 1);
  localparam int     AREA_SHIFT = 12;
  localparam longint AREA_ROUND = longint'(1) << (AREA_SHIFT - 1);

  localparam int OUT_LEAD_LSB = SUM_W;
  localparam int OUT_ISO_LSB  = SUM_W + PT_BITS;
  localparam int OUT_OK_BIT   = SUM_W + PT_BITS + ISO_W;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 40;

  typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_style_t;

  typedef struct {
    logic                         op;
    logic signed [ANGLE_BITS-1:0] eta;
    logic signed [ANGLE_BITS-1:0] phi;
    logic [PT_BITS-1:0]           pt;
    logic [PT_BITS-1:0]           pt_sub;
    logic [WEIGHT_W-1:0]          weight;
    logic [IDX_W-1:0]             idx;
    logic                         has_own;
    logic [RHO_W-1:0]             rho;
    logic                         rho_ok;
    logic                         ends_list;
  } cone_req_t;

  typedef struct {
    logic [SUM_W-1:0]   cone_sum;
    logic [PT_BITS-1:0] lead_pt;
    logic [ISO_W-1:0]   iso;
    logic               iso_ok;
  } iso_result_t;

  class ConeScoreboard;
    logic [MODE_W-1:0]            mode;
    logic [RADIUS_W-1:0]          radius_sq;
    logic [AREA_W-1:0]            area;
    logic signed [ANGLE_BITS-1:0] mu_eta;
    logic signed [ANGLE_BITS-1:0] mu_phi;
    logic [PT_BITS-1:0]           mu_pt;
    logic [IDX_W-1:0]             own_idx;
    bit                           own_ok;
    logic [RHO_W-1:0]             density;
    bit                           density_ok;
    longint                       run_sum;
    longint                       leader;
    iso_result_t                  pending_q[$];
    int                           errors;

    function new();
      mode       = MODE_RAW;
      radius_sq  = RADIUS_RESET;
      area       = AREA_RESET;
      mu_eta     = '0;
      mu_phi     = '0;
      mu_pt      = '0;
      own_idx    = '0;
      own_ok     = 1'b0;
      density    = '0;
      density_ok = 1'b0;
      run_sum    = 0;
      leader     = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_MODE:   mode = data[MODE_W-1:0];
        REG_RADIUS: radius_sq = data[RADIUS_W-1:0];
        REG_AREA:   area = data[AREA_W-1:0];
        default: ;
      endcase
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // accepted request: update muon state and cone sum, queue result on tlast
    function void note_request(cone_req_t r);
      longint                       deta;
      longint                       dr2;
      longint                       contrib;
      longint                       total;
      longint                       iso_q8;
      longint                       area_cut;
      logic signed [ANGLE_BITS-1:0] dphi;
      iso_result_t                  e;
      bit                           ok;
      if (r.op == OP_START) begin
        mu_eta     = r.eta;
        mu_phi     = r.phi;
        mu_pt      = r.pt;
        own_idx    = r.idx;
        own_ok     = r.has_own && (int'(r.idx) < MAX_PARTICLES_DEF);
        density    = r.rho;
        density_ok = r.rho_ok;
        run_sum    = 0;
        leader     = 0;
      end else begin
        deta = longint'(r.eta) - longint'(mu_eta);
        dphi = r.phi - mu_phi;  // wraps at the angle width
        dr2  = deta * deta + longint'(dphi) * longint'(dphi);
        if (!(own_ok && r.idx == own_idx) && dr2 <= longint'(radius_sq)) begin
          case (mode)
            MODE_SUBTRACTED: contrib = longint'(r.pt_sub);
            MODE_WEIGHTED: contrib = clamp(
                (longint'(r.pt) * longint'(r.weight) + Q8_ROUND) >> Q8_SHIFT, 0, PT_LIMIT);
            default: contrib = longint'(r.pt);
          endcase
          run_sum = clamp(run_sum + contrib, SUM_LO, SUM_HI);
          if (contrib > leader) leader = contrib;
        end
      end
      if (!r.ends_list) return;
      total = run_sum;
      ok    = 1'b1;
      if (mode == MODE_AREA) begin
        if (density_ok) begin
          area_cut = (longint'(density) * longint'(area) + AREA_ROUND) >> AREA_SHIFT;
          total    = clamp(total - area_cut, SUM_LO, SUM_HI);
        end else begin
          total = longint'(NO_DENSITY_SUM);
          ok    = 1'b0;
        end
      end
      if (mu_pt == '0) begin
        iso_q8 = ISO_HI;
        ok     = 1'b0;
      end else begin
        iso_q8 = clamp((total << Q8_SHIFT) / longint'(mu_pt), ISO_LO, ISO_HI);
      end
      e.cone_sum = total[SUM_W-1:0];
      e.lead_pt  = leader[PT_BITS-1:0];
      e.iso      = iso_q8[ISO_W-1:0];
      e.iso_ok   = ok;
      pending_q  = {pending_q, e};
      run_sum = 0;
      leader  = 0;
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_REPORTS) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] d);
      iso_result_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with none pending", d));
        return;
      end
      e = pending_q.pop_front();
      if (d[SUM_W-1:0] !== e.cone_sum)
        report_mismatch($sformatf("cone_sum %h, want %h", d[SUM_W-1:0], e.cone_sum));
      if (d[OUT_LEAD_LSB +: PT_BITS] !== e.lead_pt)
        report_mismatch($sformatf("lead_pt %h, want %h", d[OUT_LEAD_LSB +: PT_BITS], e.lead_pt));
      if (d[OUT_ISO_LSB +: ISO_W] !== e.iso)
        report_mismatch($sformatf("isolation %h, want %h", d[OUT_ISO_LSB +: ISO_W], e.iso));
      if (d[OUT_OK_BIT] !== e.iso_ok)
        report_mismatch($sformatf("iso_valid %b, want %b", d[OUT_OK_BIT], e.iso_ok));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  ConeScoreboard sb;
  int            cycle_cnt = 0;
  int            burst_left = 0;
  bit            tx_gaps = 1'b1;
  rx_style_t     rx_style = RX_STEADY;
  logic [15:0]   rx_pattern = 16'hFFFF;
  logic [3:0]    rx_phase = '0;
  int            hold_req_cnt = 0;
  int            hold_done = 0;
  int            hold_left = 0;
  int            mu_eta_tb = 0;
  int            mu_phi_tb = 0;
  logic [IDX_W-1:0] mu_own_tb = '0;
  int            reach = 1;

  particle_cone_isolation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // receiver: long hold when asked, otherwise its own stall style
  always @(negedge clk) begin
    if (hold_done != hold_req_cnt) begin
      hold_done  <= hold_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_STEADY: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_tready <= rx_pattern[rx_phase];
          rx_phase   <= rx_phase + 1'b1;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("particle_cone_isolation verification failed");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  function automatic logic [IN_DATA_W-1:0] pack_req(cone_req_t r);
    logic [IN_DATA_W-1:0] d;
    d        = '0;
    d[11:0]  = r.eta;
    d[23:12] = r.phi;
    d[39:24] = r.pt;
    d[55:40] = r.pt_sub;
    d[64:56] = r.weight;
    d[74:65] = r.idx;
    d[75]    = r.has_own;
    d[91:76] = r.rho;
    d[92]    = r.rho_ok;
    return d;
  endfunction

  function automatic cone_req_t mk_start(int eta, int phi, int pt, int idx, bit own,
                                         int rho, bit rho_ok, bit last_item);
    cone_req_t r;
    r           = '{default: '0};
    r.op        = OP_START;
    r.eta       = ANGLE_BITS'(eta);
    r.phi       = ANGLE_BITS'(phi);
    r.pt        = PT_BITS'(pt);
    r.idx       = IDX_W'(idx);
    r.has_own   = own;
    r.rho       = RHO_W'(rho);
    r.rho_ok    = rho_ok;
    r.ends_list = last_item;
    return r;
  endfunction

  function automatic cone_req_t mk_part(int eta, int phi, int pt, int pt_sub, int weight,
                                        int idx, bit last_item);
    cone_req_t r;
    r           = '{default: '0};
    r.op        = OP_PARTICLE;
    r.eta       = ANGLE_BITS'(eta);
    r.phi       = ANGLE_BITS'(phi);
    r.pt        = PT_BITS'(pt);
    r.pt_sub    = PT_BITS'(pt_sub);
    r.weight    = WEIGHT_W'(weight);
    r.idx       = IDX_W'(idx);
    r.ends_list = last_item;
    return r;
  endfunction

  function automatic cone_req_t rand_fields();
    cone_req_t r;
    r.op        = 1'($urandom_range(0, 1));
    r.eta       = ANGLE_BITS'($urandom_range(0, 4095));
    r.phi       = ANGLE_BITS'($urandom_range(0, 4095));
    r.pt        = PT_BITS'($urandom_range(0, 65535));
    r.pt_sub    = PT_BITS'($urandom_range(0, 65535));
    r.weight    = WEIGHT_W'($urandom_range(0, 511));
    r.idx       = IDX_W'($urandom_range(0, 1023));
    r.has_own   = 1'($urandom_range(0, 1));
    r.rho       = RHO_W'($urandom_range(0, 65535));
    r.rho_ok    = 1'($urandom_range(0, 1));
    r.ends_list = 1'b0;
    return r;
  endfunction

  function automatic cone_req_t rand_start(bit last_item);
    cone_req_t r;
    r           = rand_fields();
    r.op        = OP_START;
    r.ends_list = last_item;
    case ($urandom_range(0, 7))
      0: r.pt = '0;
      1: r.pt = PT_BITS'($urandom_range(1, 16));
      2: r.pt = '1;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) r.phi = ANGLE_BITS'($urandom_range(2040, 2055));  // near the wrap
    r.has_own = ($urandom_range(0, 3) != 0);
    r.rho_ok  = ($urandom_range(0, 4) != 0);
    return r;
  endfunction

  function automatic int cone_offset();
    if ($urandom_range(0, 5) == 0) return 0;
    return int'($urandom_range(0, 2 * reach)) - reach;
  endfunction

  function automatic cone_req_t rand_part(bit last_item);
    cone_req_t r;
    r           = rand_fields();
    r.op        = OP_PARTICLE;
    r.ends_list = last_item;
    if ($urandom_range(0, 7) != 0) begin
      r.eta = ANGLE_BITS'(mu_eta_tb + cone_offset());
      r.phi = ANGLE_BITS'(mu_phi_tb + cone_offset());
    end
    if ($urandom_range(0, 7) == 0) r.idx = mu_own_tb;
    if ($urandom_range(0, 7) != 0) r.weight = WEIGHT_W'($urandom_range(0, 256));
    if ($urandom_range(0, 7) == 0) r.pt = '1;
    return r;
  endfunction

  // one request; the sender works in bursts with idle gaps between them when tx_gaps is set
  task automatic send_req(cone_req_t r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (tx_gaps) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= pack_req(r);
    in_tuser  <= r.op;
    in_tlast  <= r.ends_list;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(r);
    if (r.op == OP_START) begin
      mu_eta_tb = int'(r.eta);
      mu_phi_tb = int'(r.phi);
      mu_own_tb = r.idx;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(addr, data);
  endtask

  task automatic configure(logic [MODE_W-1:0] mode, logic [RADIUS_W-1:0] radius,
                           logic [AREA_W-1:0] area);
    longint s;
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_RADIUS, CFG_DATA_W'(radius));
    write_reg(REG_AREA, CFG_DATA_W'(area));
    @(negedge clk);
    cfg_valid <= 1'b0;
    // particle offsets reach a bit past the cone edge
    s = 0;
    while (s * s < longint'(radius)) s++;
    reach = int'(s + s / 4 + 1);
  endtask

  task automatic run_phase(logic [MODE_W-1:0] mode, logic [RADIUS_W-1:0] radius,
                           logic [AREA_W-1:0] area, int muons, rx_style_t rx, bit squeeze);
    int n;
    int k;
    wait_drained();
    configure(mode, radius, area);
    rx_style   = rx;
    rx_pattern = 16'($urandom) | 16'h0001;
    tx_gaps    = ($urandom_range(0, 3) != 0);
    if (squeeze) begin
      tx_gaps = 1'b0;
      hold_req_cnt++;
    end
    repeat (muons) begin
      case ($urandom_range(0, 9))
        0: begin  // stray particles, no start
          n = $urandom_range(1, 3);
          for (k = 0; k < n; k++) send_req(rand_part(k == n - 1 && $urandom_range(0, 1)));
        end
        1: send_req(rand_start(1'b1));
        2: begin  // list abandoned without tlast
          send_req(rand_start(1'b0));
          n = $urandom_range(1, 4);
          repeat (n) send_req(rand_part(1'b0));
        end
        default: begin
          send_req(rand_start(1'b0));
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
          for (k = 0; k < n; k++) send_req(rand_part(k == n - 1));
        end
      endcase
    end
  endtask

  task automatic directed_requests();
    // reset muon values (pt zero), no start yet
    send_req(mk_part(0, 0, 100, 0, 0, 0, 1'b0));
    send_req(mk_part(196, 0, 65535, 0, 0, 1, 1'b1));
    send_req(mk_start(-2048, -2048, 1, 5, 1'b1, 65535, 1'b1, 1'b0));
    send_req(mk_part(-2048, 2047, 1000, 0, 0, 7, 1'b0));
    send_req(mk_part(-2048, -2048, 5000, 0, 0, 5, 1'b0));  // own particle
    send_req(mk_part(2047, 0, 65535, 0, 0, 9, 1'b0));
    send_req(mk_part(-1852, -2048, 300, 65535, 511, 1023, 1'b1));
    send_req(mk_start(2047, 2047, 65535, 1023, 1'b0, 0, 1'b0, 1'b1));
    // muon values kept after the result
    send_req(mk_part(2047, -2048, 40, 0, 0, 1023, 1'b1));
    wait_drained();
    configure(MODE_AREA, '1, '1);
    send_req(mk_start(0, 0, 1, 0, 1'b1, 65535, 1'b1, 1'b0));
    send_req(mk_part(5, -5, 10, 0, 0, 3, 1'b1));
    send_req(mk_start(0, 0, 200, 0, 1'b0, 0, 1'b0, 1'b0));
    send_req(mk_part(0, 0, 50, 0, 0, 0, 1'b1));
    wait_drained();
    configure(MODE_WEIGHTED, '0, '0);
    send_req(mk_start(100, -2048, 65535, 0, 1'b0, 0, 1'b0, 1'b0));
    send_req(mk_part(100, -2048, 65535, 0, 511, 1, 1'b0));
    send_req(mk_part(100, -2048, 12345, 0, 256, 2, 1'b0));
    send_req(mk_part(100, -2048, 65535, 0, 0, 3, 1'b0));
    send_req(mk_part(100, 2047, 777, 0, 129, 4, 1'b1));
    wait_drained();
    configure(MODE_SUBTRACTED, RADIUS_W'(1), AREA_W'(1));
    send_req(mk_start(0, 2047, 3, 0, 1'b0, 0, 1'b0, 1'b0));
    send_req(mk_part(0, -2048, 0, 65535, 0, 1, 1'b0));
    send_req(mk_part(1, 2047, 65535, 0, 0, 2, 1'b1));
  endtask

  task automatic saturating_list();
    cone_req_t r;
    int        k;
    wait_drained();
    configure(MODE_RAW, '1, AREA_RESET);
    send_req(mk_start(0, 0, 1, 0, 1'b0, 0, 1'b0, 1'b0));
    for (k = 0; k < 260; k++) begin
      r    = rand_part(k == 259);
      r.pt = '1;
      send_req(r);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_requests();
    run_phase(MODE_RAW, RADIUS_RESET, AREA_RESET, 3, RX_RANDOM, 1'b0);
    run_phase(MODE_AREA, '1, '1, 3, RX_PATTERN, 1'b0);
    run_phase(MODE_SUBTRACTED, '0, '0, 3, RX_STEADY, 1'b0);
    run_phase(MODE_WEIGHTED, RADIUS_W'($urandom_range(0, 250000)),
              AREA_W'($urandom_range(0, 65535)), 3, RX_RANDOM, 1'b0);
    run_phase(MODE_AREA, RADIUS_W'($urandom_range(20000, 400000)),
              AREA_W'($urandom_range(0, 65535)), 6, RX_STEADY, 1'b1);
    saturating_list();
    run_phase(MODE_WEIGHTED, RADIUS_W'(1), '1, 3, RX_PATTERN, 1'b0);
    run_phase(MODE_AREA, RADIUS_RESET, '0, 3, RX_RANDOM, 1'b0);
    repeat (2)
      run_phase(MODE_W'($urandom_range(0, 3)),
                RADIUS_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 33554431)
                                                      : $urandom_range(0, 250000)),
                AREA_W'($urandom_range(0, 65535)), 3, rx_style_t'($urandom_range(0, 2)),
                1'b0);

    wait_drained();
    if (sb.errors == 0)
      $display("particle_cone_isolation verification clean");
    else
      $display("particle_cone_isolation verification failed");
    $finish;
  end

endmodule
